[sv/two_led_effect_pattern_engine_assert.svh]
// assertion macros for the two-led effect pattern engine
`ifndef TWO_LED_EFFECT_PATTERN_ENGINE_ASSERT_SVH
`define TWO_LED_EFFECT_PATTERN_ENGINE_ASSERT_SVH

// checked only while out of reset
`define TLEP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TLEP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/tlep_pkg.sv]
// shared types, codes and helpers of the two-led effect pattern engine
`default_nettype none

package tlep_pkg;

    localparam logic [1:0] REG_EFFECT_MODE     = 2'd0;
    localparam logic [1:0] REG_SPEED_PERCENT   = 2'd1;
    localparam logic [1:0] REG_AUTO_CYCLE      = 2'd2;
    localparam logic [1:0] REG_PATTERN_HOLD_MS = 2'd3;

    localparam logic [3:0] EFF_SINGLE = 4'd1;
    localparam logic [3:0] EFF_OFFSET = 4'd2;
    localparam logic [3:0] EFF_SIREN  = 4'd3;

    typedef enum logic [1:0] {
        PAT_FLASH  = 2'd0,
        PAT_ROTATE = 2'd1,
        PAT_BLINK  = 2'd2,
        PAT_STROBE = 2'd3
    } t_pattern;

    typedef struct packed {
        logic [7:0] iv_wheel;
        logic [7:0] iv_df_phase;
        logic [7:0] iv_df_update;
        logic [7:0] iv_rotate;
        logic [7:0] iv_blink;
        logic [7:0] iv_strobe;
        logic [5:0] fade_step;
    } t_timing;

    // x / 100 for x up to 20000 via reciprocal multiply
    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [27:0] prod;
        prod = 28'(x) * 28'd5243;
        return prod[26:19];
    endfunction

endpackage

`default_nettype wire

[sv/tlep_timing.sv]
// update intervals and fade step derived from the speed setting
`default_nettype none

module tlep_timing (
    input  wire logic [6:0]       i_speed_percent,
    output tlep_pkg::t_timing     o_timing
);

    logic [6:0] w_speed;
    logic [6:0] w_slow;

    function automatic logic [7:0] span_map(input logic [6:0] d, input logic [7:0] lo,
                                            input logic [7:0] hi);
        logic [14:0] prod;
        prod = 15'(d) * 15'(hi - lo);
        return tlep_pkg::div100(prod) + lo;
    endfunction

    assign w_speed = (i_speed_percent > 7'd100) ? 7'd100 : i_speed_percent;
    assign w_slow  = 7'd100 - w_speed;

    always_comb begin
        o_timing.iv_wheel     = span_map(w_slow, 8'd1, 8'd100);
        o_timing.iv_df_phase  = span_map(w_slow, 8'd50, 8'd250);
        o_timing.iv_df_update = span_map(w_slow, 8'd5, 8'd20);
        o_timing.iv_rotate    = span_map(w_slow, 8'd5, 8'd30);
        o_timing.iv_blink     = span_map(w_slow, 8'd50, 8'd250);
        o_timing.iv_strobe    = span_map(w_slow, 8'd10, 8'd80);
        o_timing.fade_step    = 6'(tlep_pkg::div100(15'(w_speed) * 15'd35)) + 6'd5;
    end

endmodule

`default_nettype wire

[sv/two_led_effect_pattern_engine.sv]
// top level of the two-led effect pattern engine
//
// input channel: i_in_valid / o_in_ready carry one millisecond timestamp
// i_now_ms per transfer; the timestamp is registered, then evaluated in the
// next cycle against the effect state
// output channel: o_out_valid / i_out_ready carry both leds' colors; a
// transfer appears only on ticks where the colors are updated
// path: timestamp register, then effect logic and the output register
// throughput: one timestamp per cycle, limited only by the single output
// register; a timestamp that yields no colors never waits on the output
// when the receiver stalls, the registered timestamp holds only if it has
// colors to deliver, and o_in_ready then drops until the output drains
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at
// the clock edge (0 effect mode, 1 speed, 2 auto cycle, 3 hold period);
// write only while no timestamp is in flight
// reset: synchronous active-low i_rst_n restores the defaults (offset
// rainbow, speed 50, auto cycle on, hold 5000 ms) and empties both stages
`default_nettype none

module two_led_effect_pattern_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_now_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_led1_red,
    output logic [7:0]       o_led1_green,
    output logic [7:0]       o_led1_blue,
    output logic [7:0]       o_led2_red,
    output logic [7:0]       o_led2_green,
    output logic [7:0]       o_led2_blue,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    typedef struct packed {
        t_color led1;
        t_color led2;
    } t_leds;

    function automatic t_color wheel_step(input t_color c);
        t_color w;
        w = c;
        if (w.red != 8'd0 && w.blue == 8'd0) begin
            w.red   = w.red - 8'd1;
            w.green = w.green + 8'd1;
        end
        if (w.green != 8'd0 && w.red == 8'd0) begin
            w.green = w.green - 8'd1;
            w.blue  = w.blue + 8'd1;
        end
        if (w.blue != 8'd0 && w.green == 8'd0) begin
            w.blue = w.blue - 8'd1;
            w.red  = w.red + 8'd1;
        end
        return w;
    endfunction

    // configuration
    logic [3:0]  r_effect_mode;
    logic [6:0]  r_speed_percent;
    logic        r_auto_cycle;
    logic [15:0] r_pattern_hold_ms;

    tlep_pkg::t_timing w_timing;

    // pipeline
    logic        r_in_valid;
    logic [31:0] r_now;
    logic        r_out_valid;
    t_leds       r_leds;

    // effect state
    t_color              r_wheel_one, n_wheel_one;
    t_color              r_wheel_two, n_wheel_two;
    logic [31:0]         r_last_update, n_last_update;
    logic [31:0]         r_last_phase, n_last_phase;
    logic [31:0]         r_last_pattern, n_last_pattern;
    tlep_pkg::t_pattern  r_pattern, n_pattern;
    logic [2:0]          r_phase, n_phase;
    logic [7:0]          r_brightness, n_brightness;
    logic                r_rising, n_rising;
    logic                r_blink_on, n_blink_on;
    logic [5:0]          r_fade_step, n_fade_step;

    logic        w_result;
    t_leds       w_leds;
    logic [9:0]  w_level;
    logic [2:0]  w_owner;
    logic [3:0]  w_strobe;
    logic [31:0] w_el_update;
    logic [31:0] w_el_phase;
    logic [31:0] w_el_pattern;
    logic        w_advance;

    tlep_timing u_timing (
        .i_speed_percent (r_speed_percent),
        .o_timing        (w_timing)
    );

    assign w_el_update  = r_now - r_last_update;
    assign w_el_phase   = r_now - r_last_phase;
    assign w_el_pattern = r_now - r_last_pattern;

    always_comb begin
        n_wheel_one    = r_wheel_one;
        n_wheel_two    = r_wheel_two;
        n_last_update  = r_last_update;
        n_last_phase   = r_last_phase;
        n_last_pattern = r_last_pattern;
        n_pattern      = r_pattern;
        n_phase        = r_phase;
        n_brightness   = r_brightness;
        n_rising       = r_rising;
        n_blink_on     = r_blink_on;
        n_fade_step    = r_fade_step;
        w_result       = 1'b0;
        w_leds         = '0;
        w_level        = '0;
        w_owner        = '0;
        w_strobe       = '0;
        case (r_effect_mode)
            tlep_pkg::EFF_SINGLE, tlep_pkg::EFF_OFFSET: begin
                if (w_el_update >= 32'(w_timing.iv_wheel)) begin
                    n_last_update = r_now;
                    n_wheel_one   = wheel_step(r_wheel_one);
                    n_wheel_two   = wheel_step(r_wheel_two);
                    w_result      = 1'b1;
                    w_leds.led1   = n_wheel_one;
                    w_leds.led2   = (r_effect_mode == tlep_pkg::EFF_OFFSET) ?
                                    n_wheel_two : n_wheel_one;
                end
            end
            tlep_pkg::EFF_SIREN: begin
                if (r_auto_cycle && w_el_pattern >= 32'(r_pattern_hold_ms)) begin
                    n_last_pattern = r_now;
                    n_pattern      = tlep_pkg::t_pattern'(r_pattern + 2'd1);
                    n_phase        = 3'd0;
                    n_blink_on     = 1'b0;
                    n_brightness   = 8'd0;
                    n_rising       = 1'b1;
                end
                case (n_pattern)
                    tlep_pkg::PAT_ROTATE: begin
                        if (w_el_update >= 32'(w_timing.iv_rotate)) begin
                            n_last_update = r_now;
                            n_phase       = {1'b0, n_phase[1:0] + 2'd1};
                            w_result      = 1'b1;
                            case (n_phase[1:0])
                                2'd0:    w_leds.led1.red  = 8'hFF;
                                2'd1:    w_leds.led2.blue = 8'hFF;
                                2'd2:    w_leds.led1.blue = 8'hFF;
                                default: w_leds.led2.red  = 8'hFF;
                            endcase
                        end
                    end
                    tlep_pkg::PAT_BLINK: begin
                        if (w_el_update >= 32'(w_timing.iv_blink)) begin
                            n_last_update = r_now;
                            n_blink_on    = ~n_blink_on;
                            w_result      = 1'b1;
                            if (n_blink_on) begin
                                w_leds.led1.red  = 8'hFF;
                                w_leds.led2.blue = 8'hFF;
                            end
                        end
                    end
                    tlep_pkg::PAT_STROBE: begin
                        if (w_el_update >= 32'(w_timing.iv_strobe)) begin
                            n_last_update = r_now;
                            w_strobe      = {1'b0, n_phase} + 4'd1;
                            if (w_strobe >= 4'd6) begin
                                w_strobe = w_strobe - 4'd6;
                            end
                            n_phase  = w_strobe[2:0];
                            w_result = 1'b1;
                            if (n_phase == 3'd0 || n_phase == 3'd2) begin
                                w_leds = '1;
                            end else if (n_phase == 3'd4) begin
                                w_leds.led1.red  = 8'hFF;
                                w_leds.led2.blue = 8'hFF;
                            end
                        end
                    end
                    default: begin
                        // odd phase waits dark for the phase interval
                        if (w_el_phase >= 32'(w_timing.iv_df_phase) && n_phase[0] &&
                            n_brightness == 8'd0) begin
                            n_last_phase = r_now;
                            n_phase      = n_phase + 3'd1;
                        end
                        if (w_el_update >= 32'(w_timing.iv_df_update)) begin
                            n_last_update = r_now;
                            w_result      = 1'b1;
                            if (!n_phase[0]) begin
                                if (n_rising) begin
                                    w_level = 10'(n_brightness) + 10'({n_fade_step, 1'b0});
                                    if (w_level >= 10'd255) begin
                                        w_level  = 10'd255;
                                        n_rising = 1'b0;
                                    end
                                end else if (n_brightness <= 8'(n_fade_step)) begin
                                    w_level      = 10'd0;
                                    n_phase      = n_phase + 3'd1;
                                    n_rising     = 1'b1;
                                    n_last_phase = r_now;
                                end else begin
                                    w_level = 10'(n_brightness - 8'(n_fade_step));
                                end
                                n_brightness = w_level[7:0];
                                // a finished flash still belongs to its even phase
                                w_owner = n_phase[0] ? n_phase - 3'd1 : n_phase;
                                if (!w_owner[2]) begin
                                    w_leds.led1.red = w_level[7:0];
                                end else begin
                                    w_leds.led2.blue = w_level[7:0];
                                end
                            end
                            n_fade_step = w_timing.fade_step;
                        end
                    end
                endcase
            end
            default: begin
                w_result = 1'b0;
            end
        endcase
    end

    assign w_advance  = r_in_valid && (!w_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_mode     <= tlep_pkg::EFF_OFFSET;
            r_speed_percent   <= 7'd50;
            r_auto_cycle      <= 1'b1;
            r_pattern_hold_ms <= 16'd5000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tlep_pkg::REG_EFFECT_MODE:     r_effect_mode     <= i_cfg_data[3:0];
                tlep_pkg::REG_SPEED_PERCENT:   r_speed_percent   <= i_cfg_data[6:0];
                tlep_pkg::REG_AUTO_CYCLE:      r_auto_cycle      <= i_cfg_data[0];
                tlep_pkg::REG_PATTERN_HOLD_MS: r_pattern_hold_ms <= i_cfg_data;
                default:                       r_auto_cycle      <= r_auto_cycle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_wheel_one    <= '{red: 8'd255, green: 8'd0, blue: 8'd0};
            r_wheel_two    <= '{red: 8'd127, green: 8'd127, blue: 8'd0};
            r_last_update  <= '0;
            r_last_phase   <= '0;
            r_last_pattern <= '0;
            r_pattern      <= tlep_pkg::PAT_FLASH;
            r_phase        <= '0;
            r_brightness   <= '0;
            r_rising       <= 1'b1;
            r_blink_on     <= 1'b0;
            r_fade_step    <= 6'd15;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance && w_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance) begin
                r_wheel_one    <= n_wheel_one;
                r_wheel_two    <= n_wheel_two;
                r_last_update  <= n_last_update;
                r_last_phase   <= n_last_phase;
                r_last_pattern <= n_last_pattern;
                r_pattern      <= n_pattern;
                r_phase        <= n_phase;
                r_brightness   <= n_brightness;
                r_rising       <= n_rising;
                r_blink_on     <= n_blink_on;
                r_fade_step    <= n_fade_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_now <= i_now_ms;
        end
        if (w_advance && w_result) begin
            r_leds <= w_leds;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_led1_red   = r_leds.led1.red;
    assign o_led1_green = r_leds.led1.green;
    assign o_led1_blue  = r_leds.led1.blue;
    assign o_led2_red   = r_leds.led2.red;
    assign o_led2_green = r_leds.led2.green;
    assign o_led2_blue  = r_leds.led2.blue;

endmodule

`default_nettype wire

[sv/tlep_checker.sv]
// port-level checks of the two-led effect pattern engine and their binding
`default_nettype none

`include "two_led_effect_pattern_engine_assert.svh"

module tlep_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [31:0] i_now_ms,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  o_led1_red,
    input wire logic [7:0]  o_led1_green,
    input wire logic [7:0]  o_led1_blue,
    input wire logic [7:0]  o_led2_red,
    input wire logic [7:0]  o_led2_green,
    input wire logic [7:0]  o_led2_blue,
    input wire logic        i_cfg_we
);

    logic [47:0] w_leds;

    assign w_leds = {o_led1_red, o_led1_green, o_led1_blue,
                     o_led2_red, o_led2_green, o_led2_blue};

    // a stalled result keeps its colors
    `TLEP_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(w_leds), "result changed while stalled")

    // input back-pressure comes only from a stalled output
    `TLEP_ASSERT(a_ready_stall, i_clk, i_rst_n, !o_in_ready |-> o_out_valid && !i_out_ready, "input stalled without output stall")

    // reset empties both stages
    `TLEP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready, "pipeline not empty after reset")

    // a configuration write with a waiting timestamp gives no back-pressure by itself
    `TLEP_ASSERT(a_cfg_no_stall, i_clk, i_rst_n, i_cfg_we && !o_out_valid |-> o_in_ready, "configuration write stalled input")

    // a transferred timestamp is fully known
    `TLEP_ASSERT(a_in_known, i_clk, i_rst_n, i_in_valid && o_in_ready |-> !$isunknown(i_now_ms), "timestamp unknown on transfer")

endmodule

bind two_led_effect_pattern_engine tlep_checker u_tlep_checker (.*);

`default_nettype wire

[tb/led_color_compare.sv]
// transfer monitor, color predictor and comparator for the two-led effect pattern engine
`timescale 1ns / 1ps

module led_color_compare (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_led1_red,
    input  wire logic [7:0]  i_led1_green,
    input  wire logic [7:0]  i_led1_blue,
    input  wire logic [7:0]  i_led2_red,
    input  wire logic [7:0]  i_led2_green,
    input  wire logic [7:0]  i_led2_blue,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_waiting
);

    localparam int unsigned SPEED_MAX = 100;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_wheel;

    typedef struct packed {
        logic [7:0] led1_red;
        logic [7:0] led1_green;
        logic [7:0] led1_blue;
        logic [7:0] led2_red;
        logic [7:0] led2_green;
        logic [7:0] led2_blue;
    } t_colors;

    logic [3:0]  effect_mode;
    logic [6:0]  speed_pct;
    logic        cycle_on;
    logic [15:0] hold_ms;

    t_wheel      wheel_a;
    t_wheel      wheel_b;
    logic [31:0] last_update_ms;
    logic [31:0] last_phase_ms;
    logic [31:0] last_pattern_ms;
    tlep_pkg::t_pattern pattern;
    logic [2:0]  phase;
    logic [7:0]  brightness;
    logic        rising;
    logic        blink_on;
    logic [5:0]  fade_step;

    t_colors     colors_q[$];

    function automatic int unsigned speed_clamped();
        return (speed_pct > SPEED_MAX) ? SPEED_MAX : int'(speed_pct);
    endfunction

    function automatic int unsigned delay_ms(input int unsigned lo, input int unsigned hi);
        return (SPEED_MAX - speed_clamped()) * (hi - lo) / SPEED_MAX + lo;
    endfunction

    function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] past);
        return now - past;
    endfunction

    function automatic t_wheel wheel_step(input t_wheel w);
        if (w.red != 0 && w.blue == 0) begin
            w.red   = w.red - 8'd1;
            w.green = w.green + 8'd1;
        end
        if (w.green != 0 && w.red == 0) begin
            w.green = w.green - 8'd1;
            w.blue  = w.blue + 8'd1;
        end
        if (w.blue != 0 && w.green == 0) begin
            w.blue = w.blue - 8'd1;
            w.red  = w.red + 8'd1;
        end
        return w;
    endfunction

    function automatic t_colors colors(input int unsigned r1, input int unsigned g1,
                                       input int unsigned b1, input int unsigned r2,
                                       input int unsigned g2, input int unsigned b2);
        return {8'(r1), 8'(g1), 8'(b1), 8'(r2), 8'(g2), 8'(b2)};
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR %s at %0t ns", what, $time);
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic compare_field(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task automatic flash_tick(input logic [31:0] now);
        int unsigned lvl;
        logic [2:0]  owner;
        // odd phase waits out its gap, but only once the light is off
        if (since(now, last_phase_ms) >= delay_ms(50, 250) && phase[0] && brightness == 0) begin
            last_phase_ms = now;
            phase = phase + 3'd1;
        end
        if (since(now, last_update_ms) >= delay_ms(5, 20)) begin
            last_update_ms = now;
            if (!phase[0]) begin
                if (rising) begin
                    lvl = brightness + 2 * fade_step;
                    if (lvl >= 255) begin
                        lvl = 255;
                        rising = 1'b0;
                    end
                end else if (brightness <= fade_step) begin
                    lvl = 0;
                    phase = phase + 3'd1;
                    rising = 1'b1;
                    last_phase_ms = now;
                end else begin
                    lvl = brightness - fade_step;
                end
                brightness = 8'(lvl);
                owner = phase[0] ? phase - 3'd1 : phase;
                if (owner < 3'd4)
                    colors_q.push_back(colors(lvl, 0, 0, 0, 0, 0));
                else
                    colors_q.push_back(colors(0, 0, 0, 0, 0, lvl));
            end else begin
                colors_q.push_back(colors(0, 0, 0, 0, 0, 0));
            end
            fade_step = 6'(speed_clamped() * 35 / 100 + 5);
        end
    endtask

    task automatic siren_tick(input logic [31:0] now);
        if (cycle_on && since(now, last_pattern_ms) >= hold_ms) begin
            last_pattern_ms = now;
            pattern = tlep_pkg::t_pattern'(pattern + 2'd1);
            phase = '0;
            blink_on = 1'b0;
            brightness = '0;
            rising = 1'b1;
        end
        case (pattern)
            tlep_pkg::PAT_ROTATE: begin
                if (since(now, last_update_ms) >= delay_ms(5, 30)) begin
                    last_update_ms = now;
                    phase = {1'b0, phase[1:0] + 2'd1};
                    case (phase[1:0])
                        2'd0: colors_q.push_back(colors(255, 0, 0, 0, 0, 0));
                        2'd1: colors_q.push_back(colors(0, 0, 0, 0, 0, 255));
                        2'd2: colors_q.push_back(colors(0, 0, 255, 0, 0, 0));
                        default: colors_q.push_back(colors(0, 0, 0, 255, 0, 0));
                    endcase
                end
            end
            tlep_pkg::PAT_BLINK: begin
                if (since(now, last_update_ms) >= delay_ms(50, 250)) begin
                    last_update_ms = now;
                    blink_on = !blink_on;
                    if (blink_on)
                        colors_q.push_back(colors(255, 0, 0, 0, 0, 255));
                    else
                        colors_q.push_back(colors(0, 0, 0, 0, 0, 0));
                end
            end
            tlep_pkg::PAT_STROBE: begin
                if (since(now, last_update_ms) >= delay_ms(10, 80)) begin
                    last_update_ms = now;
                    phase = 3'((int'(phase) + 1) % 6);
                    if (phase == 3'd0 || phase == 3'd2)
                        colors_q.push_back(colors(255, 255, 255, 255, 255, 255));
                    else if (phase == 3'd4)
                        colors_q.push_back(colors(255, 0, 0, 0, 0, 255));
                    else
                        colors_q.push_back(colors(0, 0, 0, 0, 0, 0));
                end
            end
            default: flash_tick(now);
        endcase
    endtask

    task automatic predict_tick(input logic [31:0] now);
        if (effect_mode == tlep_pkg::EFF_SINGLE || effect_mode == tlep_pkg::EFF_OFFSET) begin
            if (since(now, last_update_ms) >= delay_ms(1, 100)) begin
                last_update_ms = now;
                wheel_a = wheel_step(wheel_a);
                wheel_b = wheel_step(wheel_b);
                if (effect_mode == tlep_pkg::EFF_OFFSET)
                    colors_q.push_back(t_colors'({wheel_a, wheel_b}));
                else
                    colors_q.push_back(t_colors'({wheel_a, wheel_a}));
            end
        end else if (effect_mode == tlep_pkg::EFF_SIREN) begin
            siren_tick(now);
        end
    endtask

    always @(posedge i_clk) begin
        t_colors want;
        if (!i_rst_n) begin
            effect_mode = tlep_pkg::EFF_OFFSET;
            speed_pct = 7'd50;
            cycle_on = 1'b1;
            hold_ms = 16'd5000;
            wheel_a = {8'd255, 8'd0, 8'd0};
            wheel_b = {8'd127, 8'd127, 8'd0};
            last_update_ms = '0;
            last_phase_ms = '0;
            last_pattern_ms = '0;
            pattern = tlep_pkg::PAT_FLASH;
            phase = '0;
            brightness = '0;
            rising = 1'b1;
            blink_on = 1'b0;
            fade_step = 6'd15;
            colors_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (colors_q.size() == 0) begin
                    report_mismatch("color transfer with nothing expected");
                end else begin
                    want = colors_q.pop_front();
                    compare_field("led1_red", i_led1_red, want.led1_red);
                    compare_field("led1_green", i_led1_green, want.led1_green);
                    compare_field("led1_blue", i_led1_blue, want.led1_blue);
                    compare_field("led2_red", i_led2_red, want.led2_red);
                    compare_field("led2_green", i_led2_green, want.led2_green);
                    compare_field("led2_blue", i_led2_blue, want.led2_blue);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tlep_pkg::REG_EFFECT_MODE:     effect_mode = i_cfg_data[3:0];
                    tlep_pkg::REG_SPEED_PERCENT:   speed_pct = i_cfg_data[6:0];
                    tlep_pkg::REG_AUTO_CYCLE:      cycle_on = i_cfg_data[0];
                    tlep_pkg::REG_PATTERN_HOLD_MS: hold_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_tick(i_now_ms);
        end
        o_waiting = colors_q.size();
    end

endmodule

[tb/testbench.sv]
// stimulus, clock, reset and verdict for the two-led effect pattern engine
`timescale 1ns / 1ps

module testbench;

    localparam logic [3:0] EFF_IDLE_ZERO = 4'd0;
    localparam logic [3:0] EFF_IDLE_TOP  = 4'd15;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 6;
    localparam int QUIET_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 16;
    localparam int PHASE_TICKS     = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = tlep_pkg::REG_EFFECT_MODE;
    logic [15:0] i_cfg_data = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_led1_red, o_led1_green, o_led1_blue;
    logic [7:0]  o_led2_red, o_led2_green, o_led2_blue;

    int          fail_count;
    int          waiting;
    int          quiet_cycles = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    bit          rx_hold_req = 1'b0;
    logic [31:0] clock_ms = '0;

    always #6 i_clk = ~i_clk;

    two_led_effect_pattern_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_now_ms     (i_now_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_led1_red   (o_led1_red),
        .o_led1_green (o_led1_green),
        .o_led1_blue  (o_led1_blue),
        .o_led2_red   (o_led2_red),
        .o_led2_green (o_led2_green),
        .o_led2_blue  (o_led2_blue),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    led_color_compare color_compare (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_now_ms     (i_now_ms),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_led1_red   (o_led1_red),
        .i_led1_green (o_led1_green),
        .i_led1_blue  (o_led1_blue),
        .i_led2_red   (o_led2_red),
        .i_led2_green (o_led2_green),
        .i_led2_blue  (o_led2_blue),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("FAIL two_led_effect_pattern_engine");
                $finish;
            end
        end
    end

    initial begin : receiver
        int unsigned gap;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 10);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    task automatic send_tick(input logic [31:0] stamp);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now_ms <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [3:0] mode, input logic [6:0] speed,
                             input logic cycle, input logic [15:0] hold);
        i_cfg_we <= 1'b1;
        i_cfg_index <= tlep_pkg::REG_EFFECT_MODE;
        i_cfg_data <= 16'(mode);
        @(negedge i_clk);
        i_cfg_index <= tlep_pkg::REG_SPEED_PERCENT;
        i_cfg_data <= 16'(speed);
        @(negedge i_clk);
        i_cfg_index <= tlep_pkg::REG_AUTO_CYCLE;
        i_cfg_data <= 16'(cycle);
        @(negedge i_clk);
        i_cfg_index <= tlep_pkg::REG_PATTERN_HOLD_MS;
        i_cfg_data <= hold;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] next_tick(input int unsigned step_max);
        if ($urandom_range(0, 19) == 0)
            return $urandom();
        clock_ms = clock_ms + $urandom_range(0, step_max);
        return clock_ms;
    endfunction

    initial begin : stimulus
        logic [3:0]  mode;
        logic [6:0]  speed;
        logic        cycle;
        logic [15:0] hold;
        int unsigned step_max;
        int unsigned pick;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults after reset, timestamps crossing the wrap
        send_tick(32'd0);
        send_tick(32'd50);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd49);

        // speed above range acts as full speed
        settle();
        configure(tlep_pkg::EFF_SINGLE, 7'd127, 1'b1, 16'd5000);
        send_tick(32'd100);
        send_tick(32'd100);
        send_tick(32'd101);

        settle();
        configure(EFF_IDLE_ZERO, 7'd50, 1'b1, 16'd5000);
        send_tick(32'd5000);
        settle();
        configure(EFF_IDLE_TOP, 7'd50, 1'b1, 16'd5000);
        send_tick(32'd9000);

        // zero hold period walks through every pattern
        settle();
        configure(tlep_pkg::EFF_SIREN, 7'd0, 1'b1, 16'd0);
        send_tick(32'd10000);
        send_tick(32'd10300);
        send_tick(32'd10600);
        send_tick(32'd10900);
        send_tick(32'd11200);

        settle();
        configure(tlep_pkg::EFF_SIREN, 7'd100, 1'b0, 16'hFFFF);
        send_tick(32'd11201);
        send_tick(32'd11205);
        send_tick(32'd11210);

        settle();
        configure(tlep_pkg::EFF_OFFSET, 7'd0, 1'b1, 16'd1);
        send_tick(32'd20000);
        send_tick(32'd20099);
        send_tick(32'd20100);
        clock_ms = 32'd20100;

        // receiver holds off while the sender keeps pushing
        settle();
        configure(tlep_pkg::EFF_SINGLE, 7'd100, 1'b1, 16'd5000);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        rx_hold_req = 1'b1;
        repeat (40) send_tick(next_tick(3));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            pick = $urandom_range(0, 9);
            if (pick < 2)
                mode = tlep_pkg::EFF_SINGLE;
            else if (pick < 4)
                mode = tlep_pkg::EFF_OFFSET;
            else if (pick < 9)
                mode = tlep_pkg::EFF_SIREN;
            else if ($urandom_range(0, 1) == 0)
                mode = EFF_IDLE_ZERO;
            else
                mode = 4'($urandom_range(tlep_pkg::EFF_SIREN + 1, EFF_IDLE_TOP));
            case ($urandom_range(0, 7))
                0: speed = 7'd0;
                1: speed = 7'd100;
                2: speed = 7'($urandom_range(101, 127));
                default: speed = 7'($urandom_range(0, 100));
            endcase
            cycle = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 7))
                0: hold = 16'd0;
                1: hold = 16'hFFFF;
                2: hold = 16'($urandom_range(0, 65535));
                default: hold = 16'($urandom_range(1, 1500));
            endcase
            case ($urandom_range(0, 3))
                0: step_max = 2;
                1: step_max = 15;
                2: step_max = 40;
                default: step_max = 400;
            endcase
            if ($urandom_range(0, 3) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            configure(mode, speed, cycle, hold);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            repeat (PHASE_TICKS) send_tick(next_tick(step_max));
        end

        i_in_valid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && waiting == 0)
            $display("PASS two_led_effect_pattern_engine");
        else
            $display("FAIL two_led_effect_pattern_engine");
        $finish;
    end

endmodule
